// File: rtl/lse_pkg.sv
// lse_pkg: shared types and codes for the LIFO stack engine.
// Used by lse_ctrl, lse_dp and lifo_stack_engine_unit; no dependencies.
package lse_pkg;

	localparam int CMD_W  = 3;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 8;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 9;	// width of entry_count and capacity_limit

	localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

	localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

	// controller -> datapath
	typedef struct packed {
		logic accept;		// input beat taken: run the single-access part of the op
		logic rev_rd_lo;
		logic rev_rd_hi;
		logic rev_wr_lo;
		logic rev_wr_hi;	// also steps the lo/hi pointers
		logic load_out;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic rev_needed;	// more than one entry held
		logic rev_more;		// another swap after the current one
		logic out_free;
	} dp_stat_t;

endpackage

// File: rtl/lse_ram.sv
// lse_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/lse_ctrl.sv
// lse_ctrl: sequencing FSM of the LIFO stack engine (accept, reverse walk, response).
// Depends on lse_pkg.
module lse_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [lse_pkg::CMD_W-1:0]   cmd,
	input  lse_pkg::dp_stat_t           stat,
	output lse_pkg::ctl_cmd_t           ctl
);
	import lse_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RESP = 3'd1;
	localparam logic [2:0] ST_RLO  = 3'd2;
	localparam logic [2:0] ST_RHI  = 3'd3;
	localparam logic [2:0] ST_WLO  = 3'd4;
	localparam logic [2:0] ST_WHI  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d       = state_q;
		ctl           = '0;
		ctl.accept    = accept;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_REVERSE && stat.rev_needed) begin
						state_d = ST_RLO;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_RLO: begin
				ctl.rev_rd_lo = 1'b1;
				state_d       = ST_RHI;
			end
			ST_RHI: begin
				ctl.rev_rd_hi = 1'b1;
				state_d       = ST_WLO;
			end
			ST_WLO: begin
				ctl.rev_wr_lo = 1'b1;
				state_d       = ST_WHI;
			end
			ST_WHI: begin
				ctl.rev_wr_hi = 1'b1;
				state_d       = stat.rev_more ? ST_RLO : ST_RESP;
			end
			ST_RESP: begin
				// hold here until the output register can take the result
				if (stat.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/lse_dp.sv
// lse_dp: datapath of the LIFO stack engine: fill count, limit register,
// reverse pointers, stack RAM and output register. Depends on lse_pkg, lse_ram.
module lse_dp #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lse_pkg::CNT_W-1:0]   cfg_wr_data,
	input  logic [lse_pkg::CMD_W-1:0]   cmd,
	input  logic [lse_pkg::VAL_W-1:0]   push_value,
	input  logic [lse_pkg::POS_W-1:0]   read_position,
	input  lse_pkg::ctl_cmd_t           ctl,
	output lse_pkg::dp_stat_t           stat,
	input  logic                        m_ready,
	output logic                        m_valid,
	output logic [lse_pkg::STAT_W-1:0]  status,
	output logic [lse_pkg::VAL_W-1:0]   read_value,
	output logic [lse_pkg::CNT_W-1:0]   entry_count,
	output logic                        is_empty,
	output logic                        is_full
);
	import lse_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = (CW > CNT_W) ? CW : CNT_W;

	logic [CNT_W-1:0]      cap_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic [CW-1:0]         cnt_m1;
	logic [AW-1:0]         lo_q;
	logic [AW-1:0]         hi_q;
	logic [AW-1:0]         nxt_lo;
	logic [AW-1:0]         nxt_hi;
	logic [DATA_WIDTH-1:0] tmp_q;
	logic [STAT_W-1:0]     acc_status;
	logic [STAT_W-1:0]     status_q;
	logic                  acc_rd;
	logic                  use_rd_q;

	logic [WW-1:0] cap_ext;
	logic [WW-1:0] lim_w;
	logic [WW-1:0] count_ext;
	logic [WW-1:0] pos_ext;
	logic          full_now;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [DATA_WIDTH-1:0]    ram_wdata;
	logic                     ram_re;
	logic [AW-1:0]            ram_raddr;
	logic [DATA_WIDTH-1:0]    ram_rdata;
	logic [DATA_WIDTH+VAL_W-1:0] push_ext;
	logic [DATA_WIDTH+VAL_W-1:0] rd_ext;
	logic [DATA_WIDTH-1:0]    push_w;
	logic [VAL_W-1:0]         rd_w;

	// effective limit: register saturated into 1..DEPTH
	assign cap_ext   = WW'(cap_q);
	assign lim_w     = (cap_ext == '0) ? WW'(1) :
	                   ((cap_ext > WW'(DEPTH)) ? WW'(DEPTH) : cap_ext);
	assign count_ext = WW'(count_q);
	assign pos_ext   = WW'(read_position);
	assign full_now  = (count_ext >= lim_w);
	assign cnt_m1    = count_q - CW'(1);

	assign push_ext = {{DATA_WIDTH{1'b0}}, push_value};
	assign push_w   = push_ext[DATA_WIDTH-1:0];
	assign rd_ext   = {{VAL_W{1'b0}}, ram_rdata};
	assign rd_w     = rd_ext[VAL_W-1:0];

	assign nxt_lo = lo_q + AW'(1);
	assign nxt_hi = hi_q - AW'(1);

	assign stat.rev_needed = (count_q > CW'(1));
	assign stat.rev_more   = (nxt_lo < nxt_hi);
	assign stat.out_free   = !m_valid || m_ready;

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = count_q[AW-1:0];
		ram_wdata  = push_w;
		ram_re     = 1'b0;
		ram_raddr  = lo_q;
		acc_status = STAT_OK;
		acc_rd     = 1'b0;
		count_d    = count_q;
		if (ctl.accept) begin
			case (cmd)
				CMD_PUSH: begin
					if (full_now) begin
						acc_status = STAT_FULL;
					end else begin
						ram_we  = 1'b1;
						count_d = count_q + CW'(1);
					end
				end
				CMD_POP: begin
					if (count_q == '0) begin
						acc_status = STAT_EMPTY;
					end else begin
						count_d   = cnt_m1;
						ram_re    = 1'b1;
						ram_raddr = cnt_m1[AW-1:0];
						acc_rd    = 1'b1;
					end
				end
				CMD_READ: begin
					if (pos_ext >= count_ext) begin
						acc_status = STAT_RANGE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = pos_ext[AW-1:0];
						acc_rd    = 1'b1;
					end
				end
				CMD_CLEAR: begin
					count_d = '0;
				end
				default: begin
				end
			endcase
		end
		if (ctl.rev_rd_lo) begin
			ram_re    = 1'b1;
			ram_raddr = lo_q;
		end
		if (ctl.rev_rd_hi) begin
			ram_re    = 1'b1;
			ram_raddr = hi_q;
		end
		// rdata holds the high entry here, tmp_q the low one
		if (ctl.rev_wr_lo) begin
			ram_we    = 1'b1;
			ram_waddr = lo_q;
			ram_wdata = ram_rdata;
		end
		if (ctl.rev_wr_hi) begin
			ram_we    = 1'b1;
			ram_waddr = hi_q;
			ram_wdata = tmp_q;
		end
	end

	lse_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
			m_valid <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			count_q <= count_d;
			if (ctl.load_out) begin
				m_valid <= 1'b1;
			end else if (m_ready) begin
				m_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			status_q <= acc_status;
			use_rd_q <= acc_rd;
			lo_q     <= '0;
			hi_q     <= cnt_m1[AW-1:0];
		end
		if (ctl.rev_rd_hi) begin
			tmp_q <= ram_rdata;
		end
		if (ctl.rev_wr_hi) begin
			lo_q <= nxt_lo;
			hi_q <= nxt_hi;
		end
		if (ctl.load_out) begin
			status      <= status_q;
			read_value  <= use_rd_q ? rd_w : '0;
			entry_count <= count_ext[CNT_W-1:0];
			is_empty    <= (count_q == '0);
			is_full     <= full_now;
		end
	end

endmodule

// File: rtl/lifo_stack_engine_unit.sv
// lifo_stack_engine_unit: top level of the array-backed LIFO stack engine.
// Depends on lse_pkg, lse_ctrl, lse_dp (and lse_ram below it).
//
//  channel  | direction | tdata fields (low bit up)                    | tuser
//  ---------+-----------+----------------------------------------------+-------
//  s_*      | in        | push_value[31:0], read_position[39:32]       | cmd
//  m_*      | out       | read_value[31:0], entry_count[40:32],        | status
//           |           | is_empty[41], is_full[42], zero pad          |
//  cfg_*    | in        | capacity_limit (write only)                  | -
//
// Push, pop, read, clear: the accept state makes the op's one RAM access (clear
// makes none), then the response. Reverse of n entries: floor(n/2) swaps, each
// of four steps set by the single read port of the stack RAM (read low, read high,
// write low, write high). arst_n clears the fill count, the output valid and the
// FSM; the limit resets to 256. RAM contents are not cleared. A stalled output
// holds the FSM in its response state; s_tready is high only when idle.
module lifo_stack_engine_unit #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,	// push_value[31:0], read_position[39:32]
	input  logic [2:0]  s_tuser,	// cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,	// read_value[31:0], entry_count[40:32],
					// is_empty[41], is_full[42], zero[47:43]
	output logic [1:0]  m_tuser,	// status[1:0]
	input  logic        cfg_wr_en,
	input  logic [8:0]  cfg_wr_data	// capacity_limit
);
	import lse_pkg::*;

	ctl_cmd_t          ctl;
	dp_stat_t          stat;
	logic [VAL_W-1:0]  read_value;
	logic [CNT_W-1:0]  entry_count;
	logic              is_empty;
	logic              is_full;

	lse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (s_tuser),
		.stat     (stat),
		.ctl      (ctl)
	);

	lse_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.cmd           (s_tuser),
		.push_value    (s_tdata[31:0]),
		.read_position (s_tdata[39:32]),
		.ctl           (ctl),
		.stat          (stat),
		.m_ready       (m_tready),
		.m_valid       (m_tvalid),
		.status        (m_tuser),
		.read_value    (read_value),
		.entry_count   (entry_count),
		.is_empty      (is_empty),
		.is_full       (is_full)
	);

	assign m_tdata = {5'b0, is_full, is_empty, entry_count, read_value};

endmodule
